/* rtl/kchg_pkg.sv */
// Shared constants and types for the key consensus hint generator.
`default_nettype none

package kchg_pkg;

  // Number of coefficient lanes that one beat carries.
  localparam int unsigned Lanes = 8;

  // Field widths.
  localparam int unsigned CoeffW = 14;
  localparam int unsigned HintW  = 6;
  localparam int unsigned KeyW   = Lanes;

  // Folding modulus and consensus threshold, both at most 16 bits wide.
  localparam int unsigned Modulus = 7681;
  localparam int unsigned Beta    = 7681;

  // Internal arithmetic width: holds twice any value below 2^16.
  localparam int unsigned ArithW = 17;
  // Width of the remainder after the key decision (never above the sum).
  localparam int unsigned RemW   = CoeffW + 2;

  localparam logic [HintW-1:0] HintMax = {HintW{1'b1}};

  typedef logic [CoeffW-1:0] coeff_t;
  typedef logic [HintW-1:0]  hint_t;
  typedef logic [RemW-1:0]   rem_t;
  typedef logic [ArithW-1:0] arith_t;

  // Load enables of the pipeline stages, driven by the top level.
  typedef struct packed {
    logic fold_en;
    logic hint_en;
    logic out_en;
  } kchg_stage_en_t;

endpackage

`default_nettype wire

/* rtl/key_consensus_hint_gen_core.sv */
// Top level of the key consensus hint generator: eight lanes and the output merge.
`default_nettype none

// Takes one beat of eight coefficients and eight noise bits per clock unless
// stalled and returns the packed key byte (coeff_0 in bit 7) and one six-bit
// hint per coefficient. Each coefficient is folded once by the modulus,
// doubled, given its noise bit (noise_bits_i bit 7 for coeff_0) and compared
// with the threshold; the key bit records that compare and the hint is the
// remainder scaled by 64 over the threshold, saturated at 63. The sustained
// rate is one beat per cycle while out_ready_i is high: eight identical lanes
// run side by side, each with a fold stage and a hint stage, and a shared
// output register holds the finished beat. An accepted beat passes the fold
// stage, the hint stage and the output register before out_valid_o. Every
// stage holds one beat, so in_ready_o stays high while the output is taken
// every cycle, and drops only when all three stages are full and out_ready_i
// is low. Items are independent; reset clears only the stage valid flags.

module key_consensus_hint_gen_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  kchg_pkg::coeff_t          coeff_0_i,
  input  kchg_pkg::coeff_t          coeff_1_i,
  input  kchg_pkg::coeff_t          coeff_2_i,
  input  kchg_pkg::coeff_t          coeff_3_i,
  input  kchg_pkg::coeff_t          coeff_4_i,
  input  kchg_pkg::coeff_t          coeff_5_i,
  input  kchg_pkg::coeff_t          coeff_6_i,
  input  kchg_pkg::coeff_t          coeff_7_i,
  input  logic [kchg_pkg::Lanes-1:0] noise_bits_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kchg_pkg::KeyW-1:0] key_byte_o,
  output kchg_pkg::hint_t           hint_0_o,
  output kchg_pkg::hint_t           hint_1_o,
  output kchg_pkg::hint_t           hint_2_o,
  output kchg_pkg::hint_t           hint_3_o,
  output kchg_pkg::hint_t           hint_4_o,
  output kchg_pkg::hint_t           hint_5_o,
  output kchg_pkg::hint_t           hint_6_o,
  output kchg_pkg::hint_t           hint_7_o
);
  import kchg_pkg::*;

  // Valid flags of the fold stage, the hint stage and the output register.
  logic fold_vld_q;
  logic hint_vld_q;
  logic out_vld_q;

  kchg_stage_en_t stage_en;

  // A stage loads when it is empty or when the stage after it moves on.
  // Stalls ripple back from out_ready_i in the same cycle.
  always_comb begin
    stage_en.out_en  = !out_vld_q || out_ready_i;
    stage_en.hint_en = !hint_vld_q || stage_en.out_en;
    stage_en.fold_en = !fold_vld_q || stage_en.hint_en;
  end

  assign in_ready_o  = stage_en.fold_en;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_vld_q <= 1'b0;
      hint_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (stage_en.fold_en) begin
        fold_vld_q <= in_valid_i;
      end
      if (stage_en.hint_en) begin
        hint_vld_q <= fold_vld_q;
      end
      if (stage_en.out_en) begin
        out_vld_q <= hint_vld_q;
      end
    end
  end

  // Spread the beat over the lanes.
  coeff_t coeff_s [Lanes];
  logic   lane_key [Lanes];
  hint_t  lane_hint [Lanes];
  hint_t  hint_s [Lanes];

  assign coeff_s[0] = coeff_0_i;
  assign coeff_s[1] = coeff_1_i;
  assign coeff_s[2] = coeff_2_i;
  assign coeff_s[3] = coeff_3_i;
  assign coeff_s[4] = coeff_4_i;
  assign coeff_s[5] = coeff_5_i;
  assign coeff_s[6] = coeff_6_i;
  assign coeff_s[7] = coeff_7_i;

  for (genvar j = 0; j < Lanes; j++) begin : g_lane
    kchg_lane u_lane (
      .clk_i      (clk_i),
      .stage_en_i (stage_en),
      .coeff_i    (coeff_s[j]),
      .noise_i    (noise_bits_i[Lanes-1-j]),
      .key_o      (lane_key[j]),
      .hint_o     (lane_hint[j])
    );
  end

  kchg_merge u_merge (
    .clk_i       (clk_i),
    .stage_en_i  (stage_en),
    .lane_key_i  (lane_key),
    .lane_hint_i (lane_hint),
    .key_byte_o  (key_byte_o),
    .hint_o      (hint_s)
  );

  assign hint_0_o = hint_s[0];
  assign hint_1_o = hint_s[1];
  assign hint_2_o = hint_s[2];
  assign hint_3_o = hint_s[3];
  assign hint_4_o = hint_s[4];
  assign hint_5_o = hint_s[5];
  assign hint_6_o = hint_s[6];
  assign hint_7_o = hint_s[7];

`ifndef SYNTH
  // Back-pressure only when every stage holds a beat and the sink stalls.
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (fold_vld_q && hint_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // An accepted beat occupies the fold stage in the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> fold_vld_q)
    else $error("accepted beat did not enter the fold stage");

  // A beat in the hint stage is never dropped while the output is blocked.
  a_hint_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hint_vld_q && !stage_en.out_en) |=> (hint_vld_q && out_vld_q))
    else $error("beat lost in the hint stage during a stall");

  // A finished beat moves into the output register when it is free.
  a_hint_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hint_vld_q && stage_en.out_en) |=> out_vld_q)
    else $error("finished beat did not reach the output register");
`endif

endmodule

`default_nettype wire

/* rtl/kchg_lane.sv */
// One coefficient lane: fold, key decision and hint quotient over two stages.
`default_nettype none

module kchg_lane (
  input  logic                    clk_i,
  input  kchg_pkg::kchg_stage_en_t stage_en_i,
  input  kchg_pkg::coeff_t        coeff_i,
  input  logic                    noise_i,
  output logic                    key_o,
  output kchg_pkg::hint_t         hint_o
);
  import kchg_pkg::*;

  // Stage one: fold, double, add noise, compare against the threshold.
  arith_t coeff_ext;
  arith_t fold_diff;
  coeff_t folded;
  arith_t sum;
  arith_t sum_diff;
  logic   key_d;
  arith_t rem_full;
  logic   sat_d;

  always_comb begin
    coeff_ext = ArithW'(coeff_i);
    fold_diff = coeff_ext - ArithW'(Modulus);
    folded    = (coeff_ext >= ArithW'(Modulus)) ? fold_diff[CoeffW-1:0] : coeff_i;
    sum       = ArithW'({folded, noise_i});
    sum_diff  = sum - ArithW'(Beta);
    key_d     = (sum >= ArithW'(Beta));
    rem_full  = key_d ? sum_diff : sum;
    sat_d     = (rem_full >= ArithW'(Beta));
  end

  logic key1_q;
  logic sat1_q;
  rem_t rem1_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i.fold_en) begin
      key1_q <= key_d;
      sat1_q <= sat_d;
      rem1_q <= rem_full[RemW-1:0];
    end
  end

  // Stage two: restoring division of rem * 2^HintW by the threshold, one
  // quotient bit per step. The remainder is below the threshold unless the
  // saturation flag is set, and then the quotient is replaced by the maximum.
  arith_t     part;
  hint_t      quot;
  hint_t      hint_d;

  always_comb begin
    part = ArithW'(rem1_q);
    quot = '0;
    for (int i = HintW - 1; i >= 0; i--) begin
      part = {part[ArithW-2:0], 1'b0};
      if (part >= ArithW'(Beta)) begin
        part    = part - ArithW'(Beta);
        quot[i] = 1'b1;
      end
    end
    hint_d = sat1_q ? HintMax : quot;
  end

  logic  key2_q;
  hint_t hint2_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i.hint_en) begin
      key2_q  <= key1_q;
      hint2_q <= hint_d;
    end
  end

  assign key_o  = key2_q;
  assign hint_o = hint2_q;

endmodule

`default_nettype wire

/* rtl/kchg_merge.sv */
// Output register that packs the lane key bits into one byte with the hints.
`default_nettype none

module kchg_merge (
  input  logic                     clk_i,
  input  kchg_pkg::kchg_stage_en_t stage_en_i,
  input  logic                     lane_key_i [kchg_pkg::Lanes],
  input  kchg_pkg::hint_t          lane_hint_i [kchg_pkg::Lanes],
  output logic [kchg_pkg::KeyW-1:0] key_byte_o,
  output kchg_pkg::hint_t          hint_o [kchg_pkg::Lanes]
);
  import kchg_pkg::*;

  logic [KeyW-1:0] key_d;
  logic [KeyW-1:0] key_q;
  hint_t           hint_q [Lanes];

  // Lane zero lands in the most significant key bit.
  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      key_d[Lanes-1-j] = lane_key_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i.out_en) begin
      key_q  <= key_d;
      hint_q <= lane_hint_i;
    end
  end

  assign key_byte_o = key_q;
  assign hint_o     = hint_q;

endmodule

`default_nettype wire
